[rtl/core/afd_pkg.sv]
// ----------------------------------------------------------------------------
// afd_pkg: shared types and constants of the circle draw block
// Register indexes, item kinds, configuration and queue word types.
// ----------------------------------------------------------------------------
package afd_pkg;

  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;

  // Input modes
  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_DRAW  = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y     = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS       = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BORDER_WIDTH = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FILL_COLOR   = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA        = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 4'd7;

  // Square root operand widths
  localparam int SQ_IN_W  = 36;
  localparam int SQ_OUT_W = 18;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_WRITE,
    KIND_READ,
    KIND_DRAW,
    KIND_OOR
  } kind_e;

  typedef struct packed {
    logic [12:0] center_x;
    logic [12:0] center_y;
    logic [12:0] radius;
    logic [12:0] border_width;
    logic [23:0] fill_color;
    logic [7:0]  alpha;
    logic [8:0]  image_width;
    logic [8:0]  image_height;
  } cfg_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [23:0] color;
  } item_t;

  // floor(u / 255) for any 16-bit u up to 65534
  function automatic logic [8:0] div255(input logic [15:0] u);
    logic [16:0] s;
    s = {1'b0, u} + 17'd1 + {9'd0, u[15:8]};
    return s[16:8];
  endfunction

endpackage

[rtl/core/afd_front.sv]
// ----------------------------------------------------------------------------
// afd_front: input queue of the circle draw block
// Accepts words, tags each with its kind and holds up to two of them for the back.
// ----------------------------------------------------------------------------
module afd_front import afd_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        push_i,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  pixel_x_i,
  input  logic [7:0]  pixel_y_i,
  input  logic [23:0] pixel_color_i,
  output logic        full_o,
  output item_t       item_o,
  output logic        item_valid_o,
  input  logic        item_pop_i
);

  item_t       slot_q [2];
  logic [1:0]  count_q, count_d;
  logic        wr_q, rd_q;
  logic [12:0] eff_w, eff_h;
  logic        outside, do_push;
  item_t       in_item;

  // Clip the image to the store size
  assign eff_w = (13'(cfg_i.image_width) < 13'(MAX_WIDTH)) ?
                 13'(cfg_i.image_width) : 13'(MAX_WIDTH);
  assign eff_h = (13'(cfg_i.image_height) < 13'(MAX_HEIGHT)) ?
                 13'(cfg_i.image_height) : 13'(MAX_HEIGHT);
  assign outside = (13'(pixel_x_i) >= eff_w) || (13'(pixel_y_i) >= eff_h);

  // Classify the incoming word
  always_comb begin
    in_item.x     = pixel_x_i;
    in_item.y     = pixel_y_i;
    in_item.color = pixel_color_i;
    case (mode_i)
      MODE_WRITE: in_item.kind = outside ? KIND_OOR : KIND_WRITE;
      MODE_READ:  in_item.kind = outside ? KIND_OOR : KIND_READ;
      MODE_DRAW:  in_item.kind = KIND_DRAW;
      default:    in_item.kind = KIND_NONE;
    endcase
  end

  assign full_o       = (count_q == 2'd2);
  assign item_valid_o = (count_q != 2'd0);
  assign item_o       = slot_q[rd_q];
  assign do_push      = push_i && !full_o;

  always_comb begin
    count_d = count_q;
    if (do_push && !item_pop_i) begin
      count_d = count_q + 2'd1;
    end else if (!do_push && item_pop_i) begin
      count_d = count_q - 2'd1;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
    end else begin
      count_q <= count_d;
      if (do_push) begin
        wr_q <= !wr_q;
      end
      if (item_pop_i) begin
        rd_q <= !rd_q;
      end
    end
  end

  // Store the word
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= in_item;
    end
  end

endmodule

[rtl/core/afd_sqrt.sv]
// ----------------------------------------------------------------------------
// afd_sqrt: iterative integer square root
// Restoring method, one root bit per cycle; done pulses with the root.
// ----------------------------------------------------------------------------
module afd_sqrt import afd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [SQ_IN_W-1:0]  radicand_i,
  output logic                done_o,
  output logic [SQ_OUT_W-1:0] root_o
);

  localparam int CNT_W = $clog2(SQ_OUT_W + 1);
  localparam int REM_W = SQ_OUT_W + 3;

  logic [SQ_IN_W-1:0]  rad_q;
  logic [SQ_OUT_W-1:0] root_q;
  logic [REM_W-2:0]    rem_q;
  logic [CNT_W-1:0]    cnt_q;
  logic                busy_q, done_q;
  logic [REM_W-1:0]    rem_sh, trial;
  logic                take;

  assign rem_sh = {rem_q[REM_W-4:0], rad_q[SQ_IN_W-1 -: 2]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign take   = (rem_sh >= trial);

  // Produce one root bit per step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(SQ_OUT_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q <= {rad_q[SQ_IN_W-3:0], 2'b00};
      if (take) begin
        rem_q  <= (REM_W-1)'(rem_sh - trial);
        root_q <= {root_q[SQ_OUT_W-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh[REM_W-2:0];
        root_q <= {root_q[SQ_OUT_W-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

[rtl/core/afd_back.sv]
// ----------------------------------------------------------------------------
// afd_back: frame store and draw sequencer
// Executes queued words against the frame store and holds the result word.
// ----------------------------------------------------------------------------
module afd_back import afd_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  item_t       item_i,
  input  logic        item_valid_i,
  output logic        item_pop_o,
  input  logic        pop_i,
  output logic        empty_o,
  output logic [23:0] read_color_o,
  output logic        status_o
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_RD    = 4'd1;
  localparam logic [3:0] ST_BOX   = 4'd2;
  localparam logic [3:0] ST_SQX   = 4'd3;
  localparam logic [3:0] ST_SQY   = 4'd4;
  localparam logic [3:0] ST_SQRT  = 4'd5;
  localparam logic [3:0] ST_COV   = 4'd6;
  localparam logic [3:0] ST_MUL1  = 4'd7;
  localparam logic [3:0] ST_MUL2  = 4'd8;
  localparam logic [3:0] ST_BLEND = 4'd9;
  localparam logic [3:0] ST_WRITE = 4'd10;

  logic [23:0] mem [DEPTH];
  logic [23:0] rd_q;

  logic [3:0]  st_q, st_d;
  logic [10:0] x_q, x_d, y_q, y_d, ylo_q, ylo_d, xhi_q, xhi_d, yhi_q, yhi_d;
  logic [31:0] sqx_q, sqx_d;
  logic [SQ_OUT_W-1:0] dist_q;
  logic [8:0]  outer_q, outer_d, inner_q, inner_d;
  logic [17:0] oi_q;
  logic [24:0] n_q;
  logic signed [33:0] prod_q [3];
  logic signed [33:0] prod_d [3];

  logic        out_valid_q, out_valid_d, out_status_q, out_status_d;
  logic [23:0] out_color_q, out_color_d;
  logic        out_free;

  logic        mem_we, mem_re;
  logic [AW-1:0] mem_addr;
  logic [23:0] mem_wdata;
  logic [10:0] cur_x, cur_y;
  logic [23:0] addr_full;

  logic [12:0] eff_w, eff_h;
  logic signed [14:0] tx, ty;
  logic [14:0] hx, hy;
  logic [10:0] xlo, ylo, xhi, yhi;
  logic signed [15:0] dx, dy;
  logic [27:0] d2;
  logic        sq_start, sq_done;
  logic [SQ_OUT_W-1:0] sq_root;
  logic signed [13:0] thr;
  logic signed [20:0] outer_raw, inner_raw;
  logic [23:0] blend_pix;

  afd_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sq_start),
    .radicand_i ({d2, 8'd0}),
    .done_o     (sq_done),
    .root_o     (sq_root)
  );

  assign out_free = !out_valid_q || pop_i;

  // Clipped image size and bounding box
  assign eff_w = (13'(cfg_i.image_width) < 13'(MAX_WIDTH)) ?
                 13'(cfg_i.image_width) : 13'(MAX_WIDTH);
  assign eff_h = (13'(cfg_i.image_height) < 13'(MAX_HEIGHT)) ?
                 13'(cfg_i.image_height) : 13'(MAX_HEIGHT);
  assign tx  = $signed({2'b00, cfg_i.center_x}) - $signed({2'b00, cfg_i.radius}) - 15'sd16;
  assign ty  = $signed({2'b00, cfg_i.center_y}) - $signed({2'b00, cfg_i.radius}) - 15'sd16;
  assign hx  = {2'b00, cfg_i.center_x} + {2'b00, cfg_i.radius} + 15'd16;
  assign hy  = {2'b00, cfg_i.center_y} + {2'b00, cfg_i.radius} + 15'd16;
  assign xlo = tx[14] ? 11'd0 : tx[14:4];
  assign ylo = ty[14] ? 11'd0 : ty[14:4];
  assign xhi = (13'(hx[14:4]) < (eff_w - 13'd1)) ? hx[14:4] : 11'(eff_w - 13'd1);
  assign yhi = (13'(hy[14:4]) < (eff_h - 13'd1)) ? hy[14:4] : 11'(eff_h - 13'd1);

  // Offsets from the centre and squared distance
  assign dx = $signed({1'b0, x_q, 4'd0}) - $signed({3'b000, cfg_i.center_x});
  assign dy = $signed({1'b0, y_q, 4'd0}) - $signed({3'b000, cfg_i.center_y});
  assign sqx_d = 32'(dx) * 32'(dx);
  assign d2 = 28'(sqx_q + 32'(dy) * 32'(dy));
  assign sq_start = (st_q == ST_SQY);

  // Coverage of the outer and inner edges
  assign thr = (cfg_i.border_width == 13'd0) ? 14'sd0 :
               $signed({1'b0, cfg_i.radius}) - $signed({1'b0, cfg_i.border_width});
  assign outer_raw = $signed({4'd0, cfg_i.radius, 4'd0}) - $signed({3'd0, dist_q}) + 21'sd256;
  assign inner_raw = $signed({3'd0, dist_q}) - $signed({{3{thr[13]}}, thr, 4'd0}) + 21'sd256;
  assign outer_d = outer_raw[20] ? 9'd0 : (outer_raw > 21'sd256) ? 9'd256 : outer_raw[8:0];
  assign inner_d = inner_raw[20] ? 9'd0 : (inner_raw > 21'sd256) ? 9'd256 : inner_raw[8:0];

  // Blend each channel: old + floor((fill - old) * n / (65536 * 255))
  always_comb begin
    logic signed [8:0]  diff;
    logic signed [17:0] q;
    logic [15:0]        u;
    logic [9:0]         v;
    for (int ch = 0; ch < 3; ch++) begin
      diff = $signed({1'b0, cfg_i.fill_color[8*ch +: 8]}) - $signed({1'b0, rd_q[8*ch +: 8]});
      prod_d[ch] = 34'(diff) * 34'($signed({1'b0, n_q}));
      q = 18'(prod_q[ch] >>> 16);
      if (!q[17]) begin
        u = q[15:0];
        v = {2'b00, rd_q[8*ch +: 8]} + {1'b0, div255(u)};
      end else begin
        u = 16'(18'(-q) + 18'd254);
        v = {2'b00, rd_q[8*ch +: 8]} - {1'b0, div255(u)};
      end
      blend_pix[8*ch +: 8] = v[7:0];
    end
  end

  // Sequence words and pixels
  always_comb begin
    st_d         = st_q;
    x_d          = x_q;
    y_d          = y_q;
    ylo_d        = ylo_q;
    xhi_d        = xhi_q;
    yhi_d        = yhi_q;
    item_pop_o   = 1'b0;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_wdata    = blend_pix;
    cur_x        = x_q;
    cur_y        = y_q;
    out_valid_d  = out_valid_q && !pop_i;
    out_color_d  = out_color_q;
    out_status_d = out_status_q;
    case (st_q)
      ST_IDLE: begin
        cur_x     = 11'(item_i.x);
        cur_y     = 11'(item_i.y);
        mem_wdata = item_i.color;
        if (item_valid_i && out_free) begin
          item_pop_o = 1'b1;
          case (item_i.kind)
            KIND_WRITE: begin
              mem_we       = 1'b1;
              out_valid_d  = 1'b1;
              out_color_d  = '0;
              out_status_d = 1'b0;
            end
            KIND_READ: begin
              mem_re = 1'b1;
              st_d   = ST_RD;
            end
            KIND_DRAW: st_d = ST_BOX;
            KIND_OOR: begin
              out_valid_d  = 1'b1;
              out_color_d  = '0;
              out_status_d = 1'b1;
            end
            default: begin
              out_valid_d  = 1'b1;
              out_color_d  = '0;
              out_status_d = 1'b0;
            end
          endcase
        end
      end
      ST_RD: begin
        out_valid_d  = 1'b1;
        out_color_d  = rd_q;
        out_status_d = 1'b0;
        st_d         = ST_IDLE;
      end
      ST_BOX: begin
        if (eff_w == 13'd0 || eff_h == 13'd0 || xlo > xhi || ylo > yhi) begin
          out_valid_d  = 1'b1;
          out_color_d  = '0;
          out_status_d = 1'b0;
          st_d         = ST_IDLE;
        end else begin
          x_d   = xlo;
          y_d   = ylo;
          ylo_d = ylo;
          xhi_d = xhi;
          yhi_d = yhi;
          st_d  = ST_SQX;
        end
      end
      ST_SQX: begin
        mem_re = 1'b1;
        st_d   = ST_SQY;
      end
      ST_SQY: st_d = ST_SQRT;
      ST_SQRT: begin
        if (sq_done) begin
          st_d = ST_COV;
        end
      end
      ST_COV:   st_d = ST_MUL1;
      ST_MUL1:  st_d = ST_MUL2;
      ST_MUL2:  st_d = ST_BLEND;
      ST_BLEND: st_d = ST_WRITE;
      ST_WRITE: begin
        mem_we = 1'b1;
        st_d   = ST_SQX;
        if (y_q == yhi_q) begin
          y_d = ylo_q;
          if (x_q == xhi_q) begin
            out_valid_d  = 1'b1;
            out_color_d  = '0;
            out_status_d = 1'b0;
            st_d         = ST_IDLE;
          end else begin
            x_d = x_q + 11'd1;
          end
        end else begin
          y_d = y_q + 11'd1;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  assign addr_full = 24'(cur_y) * 24'(MAX_WIDTH) + 24'(cur_x);
  assign mem_addr  = addr_full[AW-1:0];

  // Hold frame store
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[mem_addr];
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    x_q          <= x_d;
    y_q          <= y_d;
    ylo_q        <= ylo_d;
    xhi_q        <= xhi_d;
    yhi_q        <= yhi_d;
    out_color_q  <= out_color_d;
    out_status_q <= out_status_d;
    if (st_q == ST_SQX) begin
      sqx_q <= sqx_d;
    end
    if (sq_done) begin
      dist_q <= sq_root;
    end
    if (st_q == ST_COV) begin
      outer_q <= outer_d;
      inner_q <= inner_d;
    end
    if (st_q == ST_MUL1) begin
      oi_q <= outer_q * inner_q;
    end
    if (st_q == ST_MUL2) begin
      n_q <= 25'(oi_q) * 25'(cfg_i.alpha);
    end
    if (st_q == ST_BLEND) begin
      for (int ch = 0; ch < 3; ch++) begin
        prod_q[ch] <= prod_d[ch];
      end
    end
  end

  assign empty_o      = !out_valid_q;
  assign read_color_o = out_color_q;
  assign status_o     = out_status_q;

endmodule

[rtl/core/antialiased_circle_draw.sv]
// ----------------------------------------------------------------------------
// antialiased_circle_draw: antialiased circle rasterizer over an RGB store
// Pixel write/read words and circle draws with coverage-weighted alpha blend.
// ----------------------------------------------------------------------------
// Every input word yields one result word. Pixel writes, out-of-image
// accesses and unused modes set their result from the idle state, pixel
// reads after one registered frame store read. A draw walks its clipped
// bounding box one pixel at a time through the 18-step square root unit
// and the multiply and blend stages; a box outside the image ends at the
// box check. A two-word input queue accepts words until full, also while
// a draw runs or a result waits to be popped. The frame store has no clearing
// pass: read only pixels that were written. Configuration is always ready.
module antialiased_circle_draw import afd_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [23:0]          cfg_data_i,
  input  logic                 push,
  output logic                 full,
  input  logic [1:0]           mode_i,
  input  logic [7:0]           pixel_x_i,
  input  logic [7:0]           pixel_y_i,
  input  logic [23:0]          pixel_color_i,
  output logic                 empty,
  input  logic                 pop,
  output logic [23:0]          read_color_o,
  output logic                 status_o
);

  cfg_t  cfg_q;
  item_t item;
  logic  item_valid, item_pop;

  assign cfg_ready_o = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q              <= '0;
      cfg_q.alpha        <= 8'd255;
      cfg_q.image_width  <= 9'd256;
      cfg_q.image_height <= 9'd256;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_CENTER_X:     cfg_q.center_x     <= cfg_data_i[12:0];
        REG_CENTER_Y:     cfg_q.center_y     <= cfg_data_i[12:0];
        REG_RADIUS:       cfg_q.radius       <= cfg_data_i[12:0];
        REG_BORDER_WIDTH: cfg_q.border_width <= cfg_data_i[12:0];
        REG_FILL_COLOR:   cfg_q.fill_color   <= cfg_data_i;
        REG_ALPHA:        cfg_q.alpha        <= cfg_data_i[7:0];
        REG_IMAGE_WIDTH:  cfg_q.image_width  <= cfg_data_i[8:0];
        REG_IMAGE_HEIGHT: cfg_q.image_height <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  afd_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .push_i        (push),
    .mode_i        (mode_i),
    .pixel_x_i     (pixel_x_i),
    .pixel_y_i     (pixel_y_i),
    .pixel_color_i (pixel_color_i),
    .full_o        (full),
    .item_o        (item),
    .item_valid_o  (item_valid),
    .item_pop_i    (item_pop)
  );

  afd_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_i       (item),
    .item_valid_i (item_valid),
    .item_pop_o   (item_pop),
    .pop_i        (pop),
    .empty_o      (empty),
    .read_color_o (read_color_o),
    .status_o     (status_o)
  );

`ifndef SYNTHESIS
  // The back only takes a word the queue holds
  assert property (@(posedge clk_i) disable iff (!rst_ni) item_pop |-> item_valid)
    else $error("back popped an empty queue");
  // A full queue always offers a word
  assert property (@(posedge clk_i) disable iff (!rst_ni) full |-> item_valid)
    else $error("queue full without a head word");
  // An out-of-image result carries no colour
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o) |-> (read_color_o == 24'd0))
    else $error("flagged result with colour");
`endif

endmodule
